FILE: hdl/srs_pkg.sv
// Shared types and constants for the skilled resource selector.
// Used by srs_cell and skilled_resource_selector; depends on nothing else.
package srs_pkg;

   localparam int NUM_RES    = 32;
   localparam int NUM_SKILLS = 8;
   localparam int SLOT_W     = $clog2(NUM_RES);
   localparam int COUNT_W    = 6;
   localparam int SKILL_W    = 3;
   localparam int LEVEL_W    = 4;
   localparam int ID_W       = 16;
   localparam int SAL_W      = 24;
   localparam int TIME_W     = 32;
   localparam int ACTION_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_WRITE_REC   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE_LEVEL = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY       = 2'd2;

   // Query transaction moving down the cell chain, with its partial answers.
   typedef struct packed {
      logic               valid;
      logic [SKILL_W-1:0] skill;
      logic [LEVEL_W-1:0] req_level;
      logic [TIME_W-1:0]  now;
      logic               found;
      logic [SAL_W-1:0]   best_sal;
      logic [ID_W-1:0]    best_id;
      logic               any_q;
      logic [TIME_W-1:0]  wait_time;
      logic [LEVEL_W-1:0] max_lvl;
   } srs_token_type;

   // Table write broadcast to every cell.
   typedef struct packed {
      logic               rec_en;
      logic               lvl_en;
      logic [SLOT_W-1:0]  slot;
      logic [ID_W-1:0]    id;
      logic [SAL_W-1:0]   salary;
      logic [TIME_W-1:0]  busy_until;
      logic [SKILL_W-1:0] skill;
      logic [LEVEL_W-1:0] level;
   } srs_write_type;

endpackage

FILE: hdl/srs_cell.sv
// One table slot: its record and skill levels, plus one stage of the query chain.
// Depends on srs_pkg.
module srs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [srs_pkg::SLOT_W-1:0]  cell_idx,
   input  logic [srs_pkg::COUNT_W-1:0] count,
   input  logic                  advance,
   input  srs_pkg::srs_write_type wr,
   input  srs_pkg::srs_token_type tok_in,
   output srs_pkg::srs_token_type tok_out
);
   import srs_pkg::*;

   logic [ID_W-1:0]    id_ff;
   logic [SAL_W-1:0]   sal_ff;
   logic [TIME_W-1:0]  busy_ff;
   logic [LEVEL_W-1:0] lvl_ff [NUM_SKILLS];
   srs_token_type      tok_ff, tok_nx_in;

   logic               active;
   logic               is_free;
   logic               qual;
   logic [LEVEL_W-1:0] lvl;
   logic [TIME_W-1:0]  w;

   assign active  = ({1'b0, cell_idx} < count) && tok_in.valid;
   assign lvl     = lvl_ff[tok_in.skill];
   assign is_free = busy_ff <= tok_in.now;
   assign qual    = lvl >= tok_in.req_level;
   assign w       = busy_ff - tok_in.now;

   always_comb begin
      tok_nx_in = tok_in;
      if (active) begin
         if (is_free && (lvl > tok_in.max_lvl)) begin
            tok_nx_in.max_lvl = lvl;
         end
         if (qual) begin
            tok_nx_in.any_q = 1'b1;
            if (is_free) begin
               tok_nx_in.wait_time = '0;
               if (!tok_in.found || (sal_ff < tok_in.best_sal)) begin
                  tok_nx_in.found    = 1'b1;
                  tok_nx_in.best_sal = sal_ff;
                  tok_nx_in.best_id  = id_ff;
               end
            end else if (w < tok_in.wait_time) begin
               tok_nx_in.wait_time = w;
            end
         end
      end
   end

   // record fields hold no reset value
   always_ff @(posedge clock) begin
      if (wr.rec_en && (wr.slot == cell_idx)) begin
         id_ff   <= wr.id;
         sal_ff  <= wr.salary;
         busy_ff <= wr.busy_until;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_SKILLS; k++) begin
            lvl_ff[k] <= '0;
         end
      end else if (wr.lvl_en && (wr.slot == cell_idx)) begin
         lvl_ff[wr.skill] <= wr.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff.valid <= tok_nx_in.valid;
      end
      if (advance) begin
         tok_ff.skill     <= tok_nx_in.skill;
         tok_ff.req_level <= tok_nx_in.req_level;
         tok_ff.now       <= tok_nx_in.now;
         tok_ff.found     <= tok_nx_in.found;
         tok_ff.best_sal  <= tok_nx_in.best_sal;
         tok_ff.best_id   <= tok_nx_in.best_id;
         tok_ff.any_q     <= tok_nx_in.any_q;
         tok_ff.wait_time <= tok_nx_in.wait_time;
         tok_ff.max_lvl   <= tok_nx_in.max_lvl;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: hdl/skilled_resource_selector.sv
// A query transaction walks a chain of 32 slot cells, one cell per cycle while the result side
// does not hold the chain, and its result is registered at the end before rsp_valid rises.
// One query at a time: a new query or write is not taken until the last query leaves the chain.
// The input stalls while a query is in the chain.
// Reset clears resources_in_use, every skill level and all handshake state;
// resource records hold garbage until written.
// Top level of the skilled resource selector; depends on srs_pkg and srs_cell.
module skilled_resource_selector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [srs_pkg::ACTION_W-1:0]  req_action,
   input  logic [srs_pkg::SLOT_W-1:0]    req_slot,
   input  logic [srs_pkg::ID_W-1:0]      req_resource_id,
   input  logic [srs_pkg::SAL_W-1:0]     req_salary,
   input  logic [srs_pkg::TIME_W-1:0]    req_busy_until,
   input  logic [srs_pkg::SKILL_W-1:0]   req_skill,
   input  logic [srs_pkg::LEVEL_W-1:0]   req_level,
   input  logic [srs_pkg::LEVEL_W-1:0]   req_required_level,
   input  logic [srs_pkg::TIME_W-1:0]    req_now,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_found,
   output logic [srs_pkg::ID_W-1:0]      rsp_best_id,
   output logic                          rsp_none_qualified,
   output logic [srs_pkg::TIME_W-1:0]    rsp_wait_time,
   output logic [srs_pkg::LEVEL_W-1:0]   rsp_max_free_level,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [srs_pkg::COUNT_W-1:0]   csr_resources_in_use
);
   import srs_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff;
   logic [ID_W-1:0]    rsp_best_id_ff;
   logic               rsp_none_ff;
   logic [TIME_W-1:0]  rsp_wait_ff;
   logic [LEVEL_W-1:0] rsp_max_ff;

   logic               accept;
   logic               query_go;
   logic               advance;
   logic               load_rsp;
   srs_write_type      wr;
   srs_token_type      chain [NUM_RES+1];

   assign accept   = req_valid && !busy_ff;
   assign query_go = accept && (req_action == ACT_QUERY);

   always_comb begin
      wr.rec_en     = accept && (req_action == ACT_WRITE_REC);
      wr.lvl_en     = accept && (req_action == ACT_WRITE_LEVEL);
      wr.slot       = req_slot;
      wr.id         = req_resource_id;
      wr.salary     = req_salary;
      wr.busy_until = req_busy_until;
      wr.skill      = req_skill;
      wr.level      = req_level;
   end

   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = query_go;
      chain[0].skill     = req_skill;
      chain[0].req_level = req_required_level;
      chain[0].now       = req_now;
      chain[0].wait_time = '1;
   end

   // hold the chain while a finished result cannot leave
   assign advance  = !(chain[NUM_RES].valid && rsp_valid_ff && rsp_stall);
   assign load_rsp = chain[NUM_RES].valid && advance;

   for (genvar i = 0; i < NUM_RES; i++) begin : g_cell
      srs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (SLOT_W'(i)),
         .count    (count_ff),
         .advance  (advance),
         .wr       (wr),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (query_go) begin
         busy_in = 1'b1;
      end else if (load_rsp) begin
         busy_in = 1'b0;
      end
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            count_ff <= csr_resources_in_use;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_found_ff   <= chain[NUM_RES].found;
         rsp_best_id_ff <= chain[NUM_RES].found ? chain[NUM_RES].best_id : '0;
         rsp_none_ff    <= !chain[NUM_RES].any_q;
         rsp_wait_ff    <= chain[NUM_RES].any_q ? chain[NUM_RES].wait_time : '1;
         rsp_max_ff     <= chain[NUM_RES].max_lvl;
      end
   end

   assign req_stall          = busy_ff;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_best_id        = rsp_best_id_ff;
   assign rsp_none_qualified = rsp_none_ff;
   assign rsp_wait_time      = rsp_wait_ff;
   assign rsp_max_free_level = rsp_max_ff;

endmodule

FILE: test/skilled_resource_selector_test.sv
// Self-checking testbench for skilled_resource_selector: table writes, query results, CSR writes.
// Predicts each query result from its own copy of the resource table; needs srs_pkg and the RTL.
module skilled_resource_selector_test;
   timeunit 1ns;
   timeprecision 1ps;
   import srs_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_PRINTED = 60;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [SLOT_W-1:0]   slot;
      logic [ID_W-1:0]     resource_id;
      logic [SAL_W-1:0]    salary;
      logic [TIME_W-1:0]   busy_until;
      logic [SKILL_W-1:0]  skill;
      logic [LEVEL_W-1:0]  level;
      logic [LEVEL_W-1:0]  required_level;
      logic [TIME_W-1:0]   now;
   } request_type;

   typedef struct packed {
      logic               found;
      logic [ID_W-1:0]    best_id;
      logic               none_qualified;
      logic [TIME_W-1:0]  wait_time;
      logic [LEVEL_W-1:0] max_free_level;
   } selection_type;

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = '0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic [ID_W-1:0]     req_resource_id = '0;
   logic [SAL_W-1:0]    req_salary = '0;
   logic [TIME_W-1:0]   req_busy_until = '0;
   logic [SKILL_W-1:0]  req_skill = '0;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic [LEVEL_W-1:0]  req_required_level = '0;
   logic [TIME_W-1:0]   req_now = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_found;
   logic [ID_W-1:0]     rsp_best_id;
   logic                rsp_none_qualified;
   logic [TIME_W-1:0]   rsp_wait_time;
   logic [LEVEL_W-1:0]  rsp_max_free_level;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_resources_in_use = '0;

   // Predicted block state.
   logic [ID_W-1:0]    pool_id [NUM_RES];
   logic [SAL_W-1:0]   pool_salary [NUM_RES];
   logic [TIME_W-1:0]  pool_busy [NUM_RES];
   logic [LEVEL_W-1:0] pool_level [NUM_RES][NUM_SKILLS] = '{default: '{default: '0}};
   logic [COUNT_W-1:0] resource_count = '0;

   selection_type expected_selections [$];

   int mismatch_count = 0;
   int queries_sent = 0;
   int writes_sent = 0;
   int settings_written = 0;
   int results_seen = 0;
   int hold_off_cycles = 0;
   int burst_left = 0;
   bit gapless = 1'b0;
   logic [TIME_W-1:0] time_center = '0;

   skilled_resource_selector DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_action(req_action), .req_slot(req_slot), .req_resource_id(req_resource_id),
      .req_salary(req_salary), .req_busy_until(req_busy_until), .req_skill(req_skill),
      .req_level(req_level), .req_required_level(req_required_level), .req_now(req_now),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_found(rsp_found), .rsp_best_id(rsp_best_id),
      .rsp_none_qualified(rsp_none_qualified), .rsp_wait_time(rsp_wait_time),
      .rsp_max_free_level(rsp_max_free_level),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_resources_in_use(csr_resources_in_use)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report_mismatch(string msg);
      if (mismatch_count < MAX_PRINTED)
         $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Cheapest free qualified slot, shortest wait among qualified, best free level.
   function automatic selection_type select_resource(request_type q);
      selection_type r;
      int span;
      int s;
      logic [LEVEL_W-1:0] lvl;
      logic free_now;
      logic [SAL_W-1:0] best_salary;
      logic [TIME_W-1:0] gap;
      r = '0;
      r.none_qualified = 1'b1;
      r.wait_time = '1;
      best_salary = '0;
      span = (resource_count > NUM_RES) ? NUM_RES : int'(resource_count);
      for (s = 0; s < span; s++) begin
         lvl = pool_level[s][q.skill];
         free_now = pool_busy[s] <= q.now;
         if (free_now && lvl > r.max_free_level)
            r.max_free_level = lvl;
         if (lvl >= q.required_level) begin
            if (free_now) begin
               r.wait_time = '0;
               if (!r.found || pool_salary[s] < best_salary) begin
                  r.found = 1'b1;
                  best_salary = pool_salary[s];
                  r.best_id = pool_id[s];
               end
            end else begin
               gap = pool_busy[s] - q.now;
               if (r.none_qualified || gap < r.wait_time)
                  r.wait_time = gap;
            end
            r.none_qualified = 1'b0;
         end
      end
      if (r.none_qualified)
         r.wait_time = '1;
      return r;
   endfunction

   task automatic absorb_request(request_type it);
      case (it.action)
         ACT_WRITE_REC: begin
            pool_id[it.slot] = it.resource_id;
            pool_salary[it.slot] = it.salary;
            pool_busy[it.slot] = it.busy_until;
            writes_sent++;
         end
         ACT_WRITE_LEVEL: begin
            pool_level[it.slot][it.skill] = it.level;
            writes_sent++;
         end
         ACT_QUERY: begin
            expected_selections.insert(expected_selections.size(), select_resource(it));
            queries_sent++;
         end
         default: ;
      endcase
   endtask

   // Call right after a rising edge; returns at the edge that accepts the transaction.
   task automatic send_request(request_type it);
      req_valid <= 1'b1;
      req_action <= it.action;
      req_slot <= it.slot;
      req_resource_id <= it.resource_id;
      req_salary <= it.salary;
      req_busy_until <= it.busy_until;
      req_skill <= it.skill;
      req_level <= it.level;
      req_required_level <= it.required_level;
      req_now <= it.now;
      do @(posedge clock); while (req_stall);
      absorb_request(it);
   endtask

   task automatic idle_requests(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic pace_requests();
      if (gapless)
         return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         idle_requests($urandom_range(1, 40));
         burst_left = $urandom_range(0, 15);
      end
   endtask

   // Write the count only with the block idle.
   task automatic write_resource_count(logic [COUNT_W-1:0] value);
      req_valid <= 1'b0;
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_resources_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      resource_count = value;
      settings_written++;
   endtask

   function automatic request_type record_item(int slot, logic [ID_W-1:0] id,
                                               logic [SAL_W-1:0] salary,
                                               logic [TIME_W-1:0] busy);
      request_type it;
      it = '0;
      it.action = ACT_WRITE_REC;
      it.slot = SLOT_W'(slot);
      it.resource_id = id;
      it.salary = salary;
      it.busy_until = busy;
      return it;
   endfunction

   function automatic request_type level_item(int slot, int skill, int lvl);
      request_type it;
      it = '0;
      it.action = ACT_WRITE_LEVEL;
      it.slot = SLOT_W'(slot);
      it.skill = SKILL_W'(skill);
      it.level = LEVEL_W'(lvl);
      return it;
   endfunction

   function automatic request_type query_item(int skill, int req_lvl, logic [TIME_W-1:0] now);
      request_type it;
      it = '0;
      it.action = ACT_QUERY;
      it.skill = SKILL_W'(skill);
      it.required_level = LEVEL_W'(req_lvl);
      it.now = now;
      return it;
   endfunction

   // Cluster times around a center so free and busy slots mix and waits tie.
   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return '1;
      if (roll < 6)
         return time_center + TIME_W'($urandom_range(0, 64)) - TIME_W'(32);
      return TIME_W'($urandom);
   endfunction

   function automatic logic [SAL_W-1:0] pick_salary();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll < 4)
         return SAL_W'($urandom_range(0, 3));
      if (roll == 4)
         return '1;
      return SAL_W'($urandom);
   endfunction

   function automatic request_type random_request();
      request_type it;
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)
         it.action = ACT_WRITE_REC;
      else if (roll < 55)
         it.action = ACT_WRITE_LEVEL;
      else if (roll < 95)
         it.action = ACT_QUERY;
      else
         it.action = ACT_UNUSED;
      it.slot = SLOT_W'($urandom);
      it.resource_id = ID_W'($urandom);
      it.salary = pick_salary();
      it.busy_until = pick_time();
      it.skill = SKILL_W'($urandom);
      it.level = LEVEL_W'($urandom);
      it.required_level = ($urandom_range(0, 3) == 0) ? '0 : LEVEL_W'($urandom);
      it.now = pick_time();
      return it;
   endfunction

   task automatic test_reset_state();
      send_request(query_item(0, 0, 32'd0));
      send_request(query_item(NUM_SKILLS - 1, 15, 32'hFFFF_FFFF));
   endtask

   // Salary ties, free boundary at busy_until == now, time extremes.
   task automatic test_directed_selection();
      send_request(record_item(0, 16'hFFFF, 24'hFF_FFFF, 32'd0));
      send_request(record_item(1, 16'h0000, 24'h00_0000, 32'hFFFF_FFFF));
      send_request(record_item(2, 16'h1234, 24'h00_0000, 32'd100));
      send_request(record_item(3, 16'hA5A5, 24'h00_0000, 32'd50));
      write_resource_count(COUNT_W'(4));
      send_request(query_item(0, 0, 32'd100));
      send_request(query_item(0, 0, 32'hFFFF_FFFF));
      send_request(query_item(0, 0, 32'd0));
   endtask

   task automatic test_skill_levels();
      send_request(level_item(1, 7, 15));
      send_request(level_item(3, 7, 9));
      send_request(level_item(0, 7, 0));
      send_request(query_item(7, 15, 32'd60));
      send_request(query_item(7, 10, 32'd49));
      send_request(query_item(5, 1, 32'd1000));
      send_request(record_item(31, 16'h5A5A, 24'h12_3456, 32'h8000_0000) | request_type'(0));
      send_request('{action: ACT_UNUSED, default: '0});
      send_request(query_item(7, 9, 32'd50));
   endtask

   task automatic load_full_table();
      int s;
      time_center = $urandom;
      for (s = 0; s < NUM_RES; s++) begin
         send_request(record_item(s, ID_W'($urandom), pick_salary(), pick_time()));
         pace_requests();
      end
   endtask

   task automatic test_random_mix(int items, logic [COUNT_W-1:0] count_value, bit no_gaps);
      request_type it;
      int done;
      write_resource_count(count_value);
      gapless = no_gaps;
      time_center = $urandom;
      done = 0;
      while (done < items) begin
         it = random_request();
         send_request(it);
         if (it.action != ACT_UNUSED)
            done++;
         pace_requests();
      end
      gapless = 1'b0;
   endtask

   // Hold the result side long enough that queries back up and stall the input.
   task automatic test_result_backpressure();
      request_type it;
      int n;
      write_resource_count(COUNT_W'(NUM_RES));
      hold_off_cycles = 400;
      for (n = 0; n < 20; n++) begin
         it = random_request();
         it.action = ACT_QUERY;
         send_request(it);
      end
   endtask

   task automatic test_drain_pause();
      request_type it;
      int n;
      write_resource_count(COUNT_W'(NUM_RES));
      for (n = 0; n < 30; n++) begin
         it = random_request();
         send_request(it);
         if (n % 10 == 9) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_selections.size() != 0);
         end
      end
   endtask

   always @(posedge clock) begin
      selection_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_selections.size() == 0) begin
            report_mismatch("result arrived with no query pending");
         end else begin
            want = expected_selections.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %0b, expected %0b", rsp_found, want.found));
            if (rsp_best_id !== want.best_id)
               report_mismatch($sformatf("best_id %h, expected %h", rsp_best_id, want.best_id));
            if (rsp_none_qualified !== want.none_qualified)
               report_mismatch($sformatf("none_qualified %0b, expected %0b",
                  rsp_none_qualified, want.none_qualified));
            if (rsp_wait_time !== want.wait_time)
               report_mismatch($sformatf("wait_time %h, expected %h",
                  rsp_wait_time, want.wait_time));
            if (rsp_max_free_level !== want.max_free_level)
               report_mismatch($sformatf("max_free_level %0d, expected %0d",
                  rsp_max_free_level, want.max_free_level));
         end
      end
   end

   // Result-side stall: random modes, overridden by a counted hold-off.
   initial begin
      stall_mode_type mode;
      int left;
      mode = STALL_NONE;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               left = $urandom_range(20, 200);
            end
            left--;
            case (mode)
               STALL_NONE: rsp_stall <= 1'b0;
               STALL_SPARSE: rsp_stall <= ($urandom_range(0, 7) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_directed_selection();
      test_skill_levels();
      load_full_table();
      test_random_mix(70, COUNT_W'(NUM_RES), 1'b0);
      test_random_mix(70, COUNT_W'($urandom_range(1, NUM_RES - 1)), 1'b0);
      test_random_mix(70, COUNT_W'(63), 1'b1);
      test_result_backpressure();
      test_random_mix(50, COUNT_W'(0), 1'b0);
      test_drain_pause();
      test_random_mix(70, COUNT_W'($urandom_range(NUM_RES + 1, 62)), 1'b0);
      test_random_mix(70, COUNT_W'(NUM_RES), 1'b0);
      req_valid <= 1'b0;
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_selections.size() != 0)
         report_mismatch($sformatf("%0d query results never arrived", expected_selections.size()));
      $display("Covered %0d queries (%0d results checked), %0d table writes,",
         queries_sent, results_seen, writes_sent);
      $display("and %0d resource-count settings including 0, 32 and 63.", settings_written);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

FILE: files.f
hdl/srs_pkg.sv
hdl/srs_cell.sv
hdl/skilled_resource_selector.sv
test/skilled_resource_selector_test.sv
